>>> hdl/nnd_pkg.sv
// ----------------------------------------------------------------------------
// nnd_pkg
// Shared widths, register indexes and types of the nearest neighbor downscaler.
// ----------------------------------------------------------------------------
package nnd_pkg;

	localparam int CHANNELS      = 4;
	localparam int MAX_DIMENSION = 4096;
	localparam int DIM_W         = $clog2(MAX_DIMENSION) + 1;
	localparam int POS_W         = $clog2(MAX_DIMENSION);
	localparam int PIXEL_W       = 32;
	localparam int INDEX_W       = 2;
	localparam int DVD_W         = 2 * DIM_W - 1;
	localparam int STEP_CNT_W    = $clog2(DVD_W);
	localparam int QUEUE_DEPTH   = 4;
	localparam int QUEUE_PTR_W   = $clog2(QUEUE_DEPTH);

	localparam logic [63:0] PIXEL_MASK_WIDE = (64'd1 << (8 * CHANNELS)) - 64'd1;
	localparam logic [PIXEL_W-1:0] PIXEL_MASK = PIXEL_MASK_WIDE[PIXEL_W-1:0];

	localparam logic [DIM_W-1:0] DIM_MAX        = DIM_W'(MAX_DIMENSION);
	localparam logic [DIM_W-1:0] RST_SRC_WIDTH  = DIM_W'(640);
	localparam logic [DIM_W-1:0] RST_SRC_HEIGHT = DIM_W'(480);
	localparam logic [DIM_W-1:0] RST_DST_WIDTH  = DIM_W'(320);

	localparam logic [INDEX_W-1:0] REG_SRC_WIDTH  = INDEX_W'(0);
	localparam logic [INDEX_W-1:0] REG_SRC_HEIGHT = INDEX_W'(1);
	localparam logic [INDEX_W-1:0] REG_DST_WIDTH  = INDEX_W'(2);

	typedef struct packed {
		logic [DIM_W-1:0] src_width;
		logic [DIM_W-1:0] src_height;
		logic [DIM_W-1:0] dst_width;
		logic             size_bad;
	} cfg_t;

	typedef struct packed {
		logic             busy;
		logic [DIM_W-1:0] step_q;
		logic [POS_W-1:0] step_r;
		logic [DIM_W-1:0] out_height;
	} ratio_t;

	typedef struct packed {
		logic [PIXEL_W-1:0] pixel;
		logic               line_end;
		logic               frame_end;
		logic               size_error;
	} result_t;

	typedef enum logic [1:0] {
		RS_IDLE,
		RS_DIV_COL,
		RS_DIV_ROW
	} ratio_state_t;

endpackage

>>> hdl/nnd_ratio.sv
// ----------------------------------------------------------------------------
// nnd_ratio
// Bit-serial divider sequencer: column step W/N with remainder, then the
// output height N*H/W, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module nnd_ratio (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  nnd_pkg::cfg_t cfg,
	output nnd_pkg::ratio_t ratio
);

	nnd_pkg::ratio_state_t state_q;
	nnd_pkg::ratio_state_t state_next;

	logic [nnd_pkg::DVD_W-1:0]      dvd_q;
	logic [nnd_pkg::DIM_W-1:0]      rem_q;
	logic [nnd_pkg::STEP_CNT_W-1:0] cnt_q;
	logic [nnd_pkg::DIM_W-1:0]      step_q_q;
	logic [nnd_pkg::POS_W-1:0]      step_r_q;
	logic [nnd_pkg::DIM_W-1:0]      height_q;

	logic [nnd_pkg::DIM_W-1:0]   divisor;
	logic [nnd_pkg::DIM_W:0]     trial;
	logic                        ge;
	logic [nnd_pkg::DIM_W-1:0]   rem_n;
	logic [nnd_pkg::DVD_W-1:0]   dvd_n;
	logic                        last_step;
	logic [2*nnd_pkg::DIM_W-1:0] product;

	always_comb begin
		divisor = (state_q == nnd_pkg::RS_DIV_COL) ? cfg.dst_width : cfg.src_width;
		trial   = {rem_q, dvd_q[nnd_pkg::DVD_W-1]};
		ge      = trial >= {1'b0, divisor};
		rem_n   = ge ? nnd_pkg::DIM_W'(trial - {1'b0, divisor}) : trial[nnd_pkg::DIM_W-1:0];
		dvd_n   = {dvd_q[nnd_pkg::DVD_W-2:0], ge};
		product = cfg.dst_width * cfg.src_height;
	end

	// next state
	always_comb begin
		state_next = state_q;
		if (start) begin
			state_next = cfg.size_bad ? nnd_pkg::RS_IDLE : nnd_pkg::RS_DIV_COL;
		end else begin
			case (state_q)
				nnd_pkg::RS_IDLE:    state_next = nnd_pkg::RS_IDLE;
				nnd_pkg::RS_DIV_COL: if (last_step) state_next = nnd_pkg::RS_DIV_ROW;
				nnd_pkg::RS_DIV_ROW: if (last_step) state_next = nnd_pkg::RS_IDLE;
				default:             state_next = nnd_pkg::RS_IDLE;
			endcase
		end
	end

	// outputs
	always_comb begin
		last_step        = cnt_q == nnd_pkg::STEP_CNT_W'(nnd_pkg::DVD_W - 1);
		ratio.busy       = state_q != nnd_pkg::RS_IDLE;
		ratio.step_q     = step_q_q;
		ratio.step_r     = step_r_q;
		ratio.out_height = height_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= nnd_pkg::RS_IDLE;
			cnt_q    <= '0;
			height_q <= '0;
		end else begin
			state_q <= state_next;
			if (start) begin
				cnt_q <= '0;
				if (cfg.size_bad) begin
					height_q <= '0;
				end
			end else if (state_q != nnd_pkg::RS_IDLE) begin
				cnt_q <= last_step ? '0 : cnt_q + 1'b1;
				if (state_q == nnd_pkg::RS_DIV_ROW && last_step) begin
					height_q <= dvd_n[nnd_pkg::DIM_W-1:0];
				end
			end
		end
	end

	// divider datapath
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= nnd_pkg::DVD_W'(cfg.src_width);
			rem_q <= '0;
		end else if (state_q == nnd_pkg::RS_DIV_COL && last_step) begin
			step_q_q <= dvd_n[nnd_pkg::DIM_W-1:0];
			step_r_q <= rem_n[nnd_pkg::POS_W-1:0];
			dvd_q    <= product[nnd_pkg::DVD_W-1:0];
			rem_q    <= '0;
		end else if (state_q != nnd_pkg::RS_IDLE) begin
			dvd_q <= dvd_n;
			rem_q <= rem_n;
		end
	end

endmodule

>>> hdl/nnd_front.sv
// ----------------------------------------------------------------------------
// nnd_front
// Frame position tracking and keep/drop classification of each source pixel.
// ----------------------------------------------------------------------------
module nnd_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         restart,
	input  logic                         accept,
	input  logic [nnd_pkg::PIXEL_W-1:0]  pixel_in,
	input  nnd_pkg::cfg_t                cfg,
	input  nnd_pkg::ratio_t              ratio,
	output logic                         res_valid,
	output nnd_pkg::result_t             res
);

	logic [nnd_pkg::POS_W-1:0] src_col_q;
	logic [nnd_pkg::POS_W-1:0] src_row_q;
	logic [nnd_pkg::DIM_W-1:0] out_col_q;
	logic [nnd_pkg::DIM_W-1:0] out_row_q;
	logic [nnd_pkg::DIM_W-1:0] want_col_q;
	logic [nnd_pkg::POS_W-1:0] col_rem_q;
	logic [nnd_pkg::DIM_W-1:0] want_row_q;
	logic [nnd_pkg::POS_W-1:0] row_rem_q;

	logic                      row_hit;
	logic                      col_hit;
	logic                      le;
	logic                      fe;
	logic                      last_col;
	logic                      last_row;
	logic [nnd_pkg::DIM_W-1:0] col_sum;
	logic                      col_carry;
	logic [nnd_pkg::POS_W-1:0] col_rem_n;
	logic [nnd_pkg::DIM_W-1:0] want_col_n;
	logic [nnd_pkg::DIM_W-1:0] row_sum;
	logic                      row_carry;
	logic [nnd_pkg::POS_W-1:0] row_rem_n;
	logic [nnd_pkg::DIM_W-1:0] want_row_n;

	always_comb begin
		row_hit = ({1'b0, src_row_q} == want_row_q) && (out_row_q < ratio.out_height);
		col_hit = row_hit && ({1'b0, src_col_q} == want_col_q) && (out_col_q < cfg.dst_width);
		le = ({1'b0, out_col_q} + (nnd_pkg::DIM_W + 1)'(1)) == {1'b0, cfg.dst_width};
		fe = le && (({1'b0, out_row_q} + (nnd_pkg::DIM_W + 1)'(1)) == {1'b0, ratio.out_height});
		last_col = ({1'b0, src_col_q} + nnd_pkg::DIM_W'(1)) >= cfg.src_width;
		last_row = ({1'b0, src_row_q} + nnd_pkg::DIM_W'(1)) >= cfg.src_height;

		col_sum    = {1'b0, col_rem_q} + {1'b0, ratio.step_r};
		col_carry  = col_sum >= cfg.dst_width;
		col_rem_n  = col_carry ? nnd_pkg::POS_W'(col_sum - cfg.dst_width)
		                       : col_sum[nnd_pkg::POS_W-1:0];
		want_col_n = want_col_q + ratio.step_q + nnd_pkg::DIM_W'(col_carry);

		row_sum    = {1'b0, row_rem_q} + {1'b0, ratio.step_r};
		row_carry  = row_sum >= cfg.dst_width;
		row_rem_n  = row_carry ? nnd_pkg::POS_W'(row_sum - cfg.dst_width)
		                       : row_sum[nnd_pkg::POS_W-1:0];
		want_row_n = want_row_q + ratio.step_q + nnd_pkg::DIM_W'(row_carry);

		res_valid = accept && !restart && (cfg.size_bad || col_hit);
		if (cfg.size_bad) begin
			res.pixel      = '0;
			res.line_end   = 1'b0;
			res.frame_end  = 1'b0;
			res.size_error = 1'b1;
		end else begin
			res.pixel      = pixel_in & nnd_pkg::PIXEL_MASK;
			res.line_end   = le;
			res.frame_end  = fe;
			res.size_error = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_col_q  <= '0;
			src_row_q  <= '0;
			out_col_q  <= '0;
			out_row_q  <= '0;
			want_col_q <= '0;
			col_rem_q  <= '0;
			want_row_q <= '0;
			row_rem_q  <= '0;
		end else if (restart) begin
			src_col_q  <= '0;
			src_row_q  <= '0;
			out_col_q  <= '0;
			out_row_q  <= '0;
			want_col_q <= '0;
			col_rem_q  <= '0;
			want_row_q <= '0;
			row_rem_q  <= '0;
		end else if (accept && !cfg.size_bad) begin
			if (!last_col) begin
				src_col_q <= src_col_q + 1'b1;
				if (col_hit) begin
					out_col_q  <= out_col_q + 1'b1;
					want_col_q <= want_col_n;
					col_rem_q  <= col_rem_n;
				end
			end else begin
				// end of a source line
				src_col_q  <= '0;
				out_col_q  <= '0;
				want_col_q <= '0;
				col_rem_q  <= '0;
				if (last_row) begin
					src_row_q  <= '0;
					out_row_q  <= '0;
					want_row_q <= '0;
					row_rem_q  <= '0;
				end else begin
					src_row_q <= src_row_q + 1'b1;
					if (row_hit) begin
						out_row_q  <= out_row_q + 1'b1;
						want_row_q <= want_row_n;
						row_rem_q  <= row_rem_n;
					end
				end
			end
		end
	end

endmodule

>>> hdl/nnd_queue.sv
// ----------------------------------------------------------------------------
// nnd_queue
// Short result queue between the classifier and the output side.
// ----------------------------------------------------------------------------
module nnd_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  nnd_pkg::result_t wr_data,
	input  logic             rd_en,
	output nnd_pkg::result_t rd_data,
	output logic             full,
	output logic             empty
);

	nnd_pkg::result_t slot_q [nnd_pkg::QUEUE_DEPTH];

	logic [nnd_pkg::QUEUE_PTR_W-1:0] wr_ptr_q;
	logic [nnd_pkg::QUEUE_PTR_W-1:0] rd_ptr_q;
	logic [nnd_pkg::QUEUE_PTR_W:0]   count_q;
	logic                            do_wr;
	logic                            do_rd;

	always_comb begin
		full    = count_q == (nnd_pkg::QUEUE_PTR_W + 1)'(nnd_pkg::QUEUE_DEPTH);
		empty   = count_q == '0;
		do_wr   = wr_en && !full;
		do_rd   = rd_en && !empty;
		rd_data = slot_q[rd_ptr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({do_wr, do_rd})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

>>> hdl/nearest_neighbor_downscaler.sv
// ----------------------------------------------------------------------------
// nearest_neighbor_downscaler
// Streaming nearest neighbor downscaler: keeps or drops raster-order pixels
// using exact integer step accumulators.
// ----------------------------------------------------------------------------
// channel   direction  handshake            word
// input     in         push / full          pixel_in
// result    out        empty / pop          pixel_out, line_end, frame_end, size_error
// config    in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// one pixel per cycle once the ratio unit is idle and the queue is not full; a kept
// word is in the four-entry queue in the cycle after its pixel.
// after reset and after every register write the serial divider computes W/N,
// then N*H/W, or skips both with an invalid geometry; full stays high meanwhile
// and in any cycle where cfg_valid is high.
// full also rises when the result queue holds four words.
// ----------------------------------------------------------------------------
module nearest_neighbor_downscaler (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	output logic                         full,
	input  logic [nnd_pkg::PIXEL_W-1:0]  pixel_in,
	output logic                         empty,
	input  logic                         pop,
	output logic [nnd_pkg::PIXEL_W-1:0]  pixel_out,
	output logic                         line_end,
	output logic                         frame_end,
	output logic                         size_error,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [nnd_pkg::INDEX_W-1:0]  cfg_index,
	input  logic [nnd_pkg::DIM_W-1:0]    cfg_data
);

	logic [nnd_pkg::DIM_W-1:0] src_width_q;
	logic [nnd_pkg::DIM_W-1:0] src_height_q;
	logic [nnd_pkg::DIM_W-1:0] dst_width_q;
	logic                      start_q;

	nnd_pkg::cfg_t    cfg;
	nnd_pkg::ratio_t  ratio;
	nnd_pkg::result_t res;
	nnd_pkg::result_t head;

	logic                      cfg_wr;
	logic                      reg_hit;
	logic [nnd_pkg::DIM_W-1:0] cfg_sat;
	logic                      accept;
	logic                      res_valid;
	logic                      queue_full;

	always_comb begin
		cfg_ready    = 1'b1;
		cfg_wr       = cfg_valid && cfg_ready;
		reg_hit      = cfg_index == nnd_pkg::REG_SRC_WIDTH ||
		               cfg_index == nnd_pkg::REG_SRC_HEIGHT ||
		               cfg_index == nnd_pkg::REG_DST_WIDTH;
		cfg_sat      = (cfg_data > nnd_pkg::DIM_MAX) ? nnd_pkg::DIM_MAX : cfg_data;
		cfg.src_width  = src_width_q;
		cfg.src_height = src_height_q;
		cfg.dst_width  = dst_width_q;
		cfg.size_bad   = (src_width_q == '0) || (dst_width_q == '0) ||
		                 (dst_width_q > src_width_q);
		full   = queue_full || ratio.busy || start_q || cfg_valid;
		accept = push && !full;
		pixel_out  = head.pixel;
		line_end   = head.line_end;
		frame_end  = head.frame_end;
		size_error = head.size_error;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_width_q  <= nnd_pkg::RST_SRC_WIDTH;
			src_height_q <= nnd_pkg::RST_SRC_HEIGHT;
			dst_width_q  <= nnd_pkg::RST_DST_WIDTH;
			start_q      <= 1'b1;
		end else begin
			start_q <= cfg_wr && reg_hit;
			if (cfg_wr) begin
				case (cfg_index)
					nnd_pkg::REG_SRC_WIDTH:  src_width_q  <= cfg_sat;
					nnd_pkg::REG_SRC_HEIGHT: src_height_q <= cfg_sat;
					nnd_pkg::REG_DST_WIDTH:  dst_width_q  <= cfg_sat;
					default: ;
				endcase
			end
		end
	end

	nnd_ratio u_ratio (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start_q),
		.cfg    (cfg),
		.ratio  (ratio)
	);

	nnd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.restart   (cfg_wr && reg_hit),
		.accept    (accept),
		.pixel_in  (pixel_in),
		.cfg       (cfg),
		.ratio     (ratio),
		.res_valid (res_valid),
		.res       (res)
	);

	nnd_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (res_valid),
		.wr_data (res),
		.rd_en   (pop),
		.rd_data (head),
		.full    (queue_full),
		.empty   (empty)
	);

endmodule
